[rtl/core/g2u_pkg.sv]
// Shared types and constants of the GB2312 to Unicode transcoder.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package g2u_pkg;

  // Map memory geometry.
  localparam int unsigned MAP_DEPTH = 8836;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam int unsigned IDX_W     = 14;
  localparam int unsigned ENTRY_W   = 40;
  localparam int unsigned UNI_W     = 16;
  localparam int unsigned UTF8_W    = 24;

  // Decoupling queue between front and back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration port.
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_FORMAT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BYTE_ORDER = 1'b1;

  // Commands carried by input items.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_CONVERT = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;

  // Source byte classes.
  localparam logic [7:0] ROW_BASE  = 8'd161;
  localparam logic [7:0] ROW_LEN   = 8'd94;
  localparam logic [7:0] LEAD_MIN  = 8'd176;
  localparam logic [7:0] LEAD_MAX  = 8'd247;
  localparam logic [7:0] TRAIL_MIN = 8'd160;
  localparam logic [7:0] TRAIL_MAX = 8'd254;
  localparam logic [7:0] HIGH_MIN  = 8'd128;

  // Work handed from front to back.
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_START,
    OP_ASCII,
    OP_PAIR_MAP,
    OP_PAIR_KEEP
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [7:0]          data_byte;
    logic [MAP_AW-1:0]   addr;
    logic [ENTRY_W-1:0]  entry;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         data_byte;
    logic [IDX_W-1:0]   map_index;
    logic [UNI_W-1:0]   map_unicode;
    logic [UTF8_W-1:0]  map_utf8;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/gb2312_to_unicode_transcoder_unit.sv]
// Top level of the GB2312 to UTF-8 / UCS-2 transcoder: configuration registers,
// front end, operation queue and back end. Depends on g2u_pkg and the g2u_* modules.
//
// Usage: the input channel (in_valid, in_stall, in_item) takes one item per cycle
// while the four-entry operation queue has room. Load items below index 8836 write
// one 40-bit map entry; start items clear the held entry and any pending lead byte;
// convert items carry one source byte. The result channel (out_valid, out_stall, out_item) gives
// one byte per cycle unless stalled, with last set on the final byte of each character.
// An ASCII item or an unmapped pair passes through the operation queue, the byte
// sequence register and the output register; a mapped pair also passes through
// the registered map memory read. The single result byte lane carries one output
// byte per cycle unless stalled, which paces a UTF-8 pair (two inputs, three bytes).
// The map memory is not cleared at reset; entries must be loaded before use.
// Reset (rst_n low, synchronous) empties the queue, drops any pending lead byte,
// clears the held entry and the configuration registers (UTF-8, high byte first).
// When the receiver stalls, the output register holds its byte, the back end stops
// at the next operation that produces bytes, and in_stall rises once the queue fills.
// Configuration must be written through the APB-style port only while the block is idle (unenforced).
`default_nettype none

module gb2312_to_unicode_transcoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire g2u_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output g2u_pkg::out_item_t                 out_item,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [g2u_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [g2u_pkg::CFG_DW-1:0]    pwdata,
  output logic [g2u_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);

  logic                               out_format_r;
  logic                               byte_order_r;
  logic                               cfg_wr;
  logic [g2u_pkg::REG_IDX_W-1:0]      reg_idx;
  logic                               q_push;
  logic                               q_pop;
  g2u_pkg::op_t                       push_op;
  g2u_pkg::op_t                       head_op;
  g2u_pkg::q_stat_t                   q_stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[g2u_pkg::CFG_AW-1:2];

  always_comb begin
    case (reg_idx)
      g2u_pkg::REG_OUT_FORMAT: prdata = {{(g2u_pkg::CFG_DW-1){1'b0}}, out_format_r};
      g2u_pkg::REG_BYTE_ORDER: prdata = {{(g2u_pkg::CFG_DW-1){1'b0}}, byte_order_r};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_format_r <= 1'b0;
      byte_order_r <= 1'b0;
    end else if (cfg_wr) begin
      if (reg_idx == g2u_pkg::REG_OUT_FORMAT) begin
        out_format_r <= pwdata[0];
      end
      if (reg_idx == g2u_pkg::REG_BYTE_ORDER) begin
        byte_order_r <= pwdata[0];
      end
    end
  end

  g2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_op  (push_op)
  );

  g2u_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .q_stat  (q_stat)
  );

  g2u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_format (out_format_r),
    .byte_order (byte_order_r),
    .head_op    (head_op),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  // The queue is never written while full nor read while empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("operation queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("operation queue read while empty");

  // No result is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty queue that receives nothing leaves the back end with nothing to take
  // in the next cycle.
  a_config_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty && !q_push && !out_valid |=> !q_pop)
    else $error("operation taken from an empty queue");

endmodule

`default_nettype wire

[rtl/core/g2u_front.sv]
// Front end: accepts input items, tracks the pending lead byte, and turns each
// item into an operation for the back end. Depends on g2u_pkg.
`default_nettype none

module g2u_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire g2u_pkg::in_item_t in_item,
  input  wire g2u_pkg::q_stat_t  q_stat,
  output logic                   push,
  output g2u_pkg::op_t           push_op
);

  logic       lead_pending_r, lead_pending_nxt;
  logic [7:0] lead_byte_r, lead_byte_nxt;
  logic       accept;
  logic [6:0] row;
  logic [g2u_pkg::IDX_W-1:0] pair_idx;
  logic       pair_ok;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Rows start at 161; only rows 176..247 and cells 160..254 are looked up.
  // A cell of 160 lands one below the row start, so the cell offset is taken
  // modulo the index width rather than as a plain 8-bit difference.
  assign row      = 7'(lead_byte_r - g2u_pkg::ROW_BASE);
  assign pair_idx = g2u_pkg::IDX_W'({7'd0, row} * {6'd0, g2u_pkg::ROW_LEN})
                  + {6'd0, in_item.data_byte} - {6'd0, g2u_pkg::ROW_BASE};
  assign pair_ok  = (lead_byte_r >= g2u_pkg::LEAD_MIN) && (lead_byte_r <= g2u_pkg::LEAD_MAX)
                 && (in_item.data_byte >= g2u_pkg::TRAIL_MIN)
                 && (in_item.data_byte <= g2u_pkg::TRAIL_MAX)
                 && (32'(pair_idx) < 32'(g2u_pkg::MAP_DEPTH));

  always_comb begin
    push              = 1'b0;
    push_op.kind      = g2u_pkg::OP_ASCII;
    push_op.data_byte = in_item.data_byte;
    push_op.addr      = g2u_pkg::MAP_AW'(in_item.map_index);
    push_op.entry     = {in_item.map_unicode, in_item.map_utf8};
    lead_pending_nxt  = lead_pending_r;
    lead_byte_nxt     = lead_byte_r;
    if (accept) begin
      case (in_item.cmd)
        g2u_pkg::CMD_LOAD: begin
          push_op.kind = g2u_pkg::OP_LOAD;
          push         = 32'(in_item.map_index) < 32'(g2u_pkg::MAP_DEPTH);
        end
        g2u_pkg::CMD_START: begin
          push_op.kind     = g2u_pkg::OP_START;
          push             = 1'b1;
          lead_pending_nxt = 1'b0;
          lead_byte_nxt    = 8'd0;
        end
        g2u_pkg::CMD_CONVERT: begin
          if (!lead_pending_r) begin
            if (in_item.data_byte < g2u_pkg::HIGH_MIN) begin
              push_op.kind = g2u_pkg::OP_ASCII;
              push         = 1'b1;
            end else begin
              lead_pending_nxt = 1'b1;
              lead_byte_nxt    = in_item.data_byte;
            end
          end else begin
            // Any byte completes a pending pair; an invalid pair reuses the held entry.
            lead_pending_nxt = 1'b0;
            push             = 1'b1;
            push_op.addr     = g2u_pkg::MAP_AW'(pair_idx);
            push_op.kind     = pair_ok ? g2u_pkg::OP_PAIR_MAP : g2u_pkg::OP_PAIR_KEEP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_byte_r    <= 8'd0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      lead_byte_r    <= lead_byte_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/g2u_queue.sv]
// Short operation queue that decouples the front end from the back end.
// Depends on g2u_pkg.
`default_nettype none

module g2u_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire g2u_pkg::op_t     push_op,
  input  wire logic             pop,
  output g2u_pkg::op_t          head_op,
  output g2u_pkg::q_stat_t      q_stat
);

  g2u_pkg::op_t              q_r [g2u_pkg::Q_DEPTH];
  logic [g2u_pkg::Q_PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [g2u_pkg::Q_CW-1:0]  cnt_r;

  assign head_op      = q_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == g2u_pkg::Q_CW'(g2u_pkg::Q_DEPTH);
  assign q_stat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/g2u_back.sv]
// Back end: owns the map memory and the held entry, executes queued operations
// in order and serializes result bytes into the output register. Depends on g2u_pkg.
`default_nettype none

module g2u_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              out_format,
  input  wire logic              byte_order,
  input  wire g2u_pkg::op_t      head_op,
  input  wire g2u_pkg::q_stat_t  q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output g2u_pkg::out_item_t     out_item
);

  logic [g2u_pkg::ENTRY_W-1:0] mem [g2u_pkg::MAP_DEPTH];
  logic [g2u_pkg::ENTRY_W-1:0] rdata_r;
  logic [g2u_pkg::ENTRY_W-1:0] held_r, held_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [23:0]                 seq_r, seq_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  g2u_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                        out_free;
  logic                        emit;
  logic                        seq_open;
  logic                        mem_we, mem_re;
  logic                        load_seq;
  logic [g2u_pkg::UNI_W-1:0]   src_uni;
  logic [g2u_pkg::UTF8_W-1:0]  src_utf8;
  logic [1:0]                  src_n;
  logic [23:0]                 new_seq;
  logic [1:0]                  new_cnt;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (cnt_r != 2'd0) && out_free;
  // The byte sequence frees up when it is empty or its last byte leaves now.
  assign seq_open = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_free);

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    load_seq = 1'b0;
    held_nxt = held_r;
    rd_pend_nxt = rd_pend_r;
    src_uni  = held_r[g2u_pkg::ENTRY_W-1 -: g2u_pkg::UNI_W];
    src_utf8 = held_r[g2u_pkg::UTF8_W-1:0];
    src_n    = 2'd3;

    if (rd_pend_r) begin
      // A mapped pair waits here with its read data until the sequence frees up.
      if (seq_open) begin
        load_seq    = 1'b1;
        rd_pend_nxt = 1'b0;
        held_nxt    = rdata_r;
        src_uni     = rdata_r[g2u_pkg::ENTRY_W-1 -: g2u_pkg::UNI_W];
        src_utf8    = rdata_r[g2u_pkg::UTF8_W-1:0];
      end
    end else if (!q_stat.empty) begin
      case (head_op.kind)
        g2u_pkg::OP_LOAD: begin
          pop    = 1'b1;
          mem_we = 1'b1;
        end
        g2u_pkg::OP_START: begin
          pop      = 1'b1;
          held_nxt = '0;
        end
        g2u_pkg::OP_PAIR_MAP: begin
          pop         = 1'b1;
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
        end
        g2u_pkg::OP_PAIR_KEEP: begin
          if (seq_open) begin
            pop      = 1'b1;
            load_seq = 1'b1;
          end
        end
        g2u_pkg::OP_ASCII: begin
          if (seq_open) begin
            pop      = 1'b1;
            load_seq = 1'b1;
            src_uni  = {8'd0, head_op.data_byte};
            src_utf8 = {head_op.data_byte, 16'd0};
            src_n    = 2'd1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    if (out_format) begin
      new_cnt = 2'd2;
      new_seq = byte_order ? {src_uni[7:0], src_uni[15:8], 8'd0}
                           : {src_uni[15:8], src_uni[7:0], 8'd0};
    end else begin
      new_cnt = src_n;
      new_seq = src_utf8;
    end
  end

  always_comb begin
    seq_nxt       = seq_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_free) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      out_item_nxt.out_byte = seq_r[23:16];
      out_item_nxt.last     = cnt_r == 2'd1;
      seq_nxt               = {seq_r[15:0], 8'd0};
      cnt_nxt               = cnt_r - 2'd1;
    end
    if (load_seq) begin
      seq_nxt = new_seq;
      cnt_nxt = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head_op.addr] <= head_op.entry;
    end
    if (mem_re) begin
      rdata_r <= mem[head_op.addr];
    end
  end

  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      rd_pend_r   <= 1'b0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      rd_pend_r   <= rd_pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[dv/gb2312_to_unicode_transcoder_unit_tb.sv]
// Self-checking testbench for the GB2312 to UTF-8 / UCS-2 transcoder unit.
// Holds its own transcoding predictor and drives random traffic with stalls on both sides.
// Depends on g2u_pkg and gb2312_to_unicode_transcoder_unit.
`timescale 1ns / 1ps

module gb2312_to_unicode_transcoder_unit_tb;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam int         RANDOM_PER_PHASE = 100;
  localparam int         DRAIN_CYCLES     = 16;
  localparam int         CYCLE_LIMIT      = 400000;

  typedef enum logic {FMT_UTF8, FMT_UCS2} fmt_t;
  typedef enum logic {HI_FIRST, LO_FIRST} order_t;
  typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_BLOCKS} stall_mode_t;

  class transcode_scoreboard;
    bit [g2u_pkg::ENTRY_W-1:0] map_mem [g2u_pkg::MAP_DEPTH];
    bit                        written [g2u_pkg::MAP_DEPTH];
    bit                        lead_pending;
    bit [7:0]                  lead_byte;
    bit [g2u_pkg::ENTRY_W-1:0] held_entry;
    fmt_t                      out_format = FMT_UTF8;
    order_t                    byte_order = HI_FIRST;
    g2u_pkg::out_item_t        expected_bytes[$];
    int                        errors;
    int                        checked;
    int                        loads;

    function bit is_mapped_pair(logic [7:0] lead, logic [7:0] trail);
      return lead >= g2u_pkg::LEAD_MIN && lead <= g2u_pkg::LEAD_MAX
          && trail >= g2u_pkg::TRAIL_MIN && trail <= g2u_pkg::TRAIL_MAX;
    endfunction

    function int unsigned map_addr(logic [7:0] lead, logic [7:0] trail);
      return (int'(lead) - int'(g2u_pkg::ROW_BASE)) * int'(g2u_pkg::ROW_LEN)
           + int'(trail) - int'(g2u_pkg::ROW_BASE);
    endfunction

    function void push_byte(logic [7:0] b, bit is_last);
      g2u_pkg::out_item_t o;
      o.out_byte = b;
      o.last     = is_last;
      expected_bytes.push_back(o);
    endfunction

    function void push_code_unit(logic [15:0] u);
      if (byte_order == LO_FIRST) begin
        push_byte(u[7:0], 1'b0);
        push_byte(u[15:8], 1'b1);
      end else begin
        push_byte(u[15:8], 1'b0);
        push_byte(u[7:0], 1'b1);
      end
    endfunction

    function void set_reg(logic [g2u_pkg::REG_IDX_W-1:0] idx, logic [g2u_pkg::CFG_DW-1:0] val);
      if (idx == g2u_pkg::REG_OUT_FORMAT) out_format = fmt_t'(val[0]);
      else if (idx == g2u_pkg::REG_BYTE_ORDER) byte_order = order_t'(val[0]);
    endfunction

    function void accept_source(g2u_pkg::in_item_t it);
      logic [7:0] b;
      b = it.data_byte;
      case (it.cmd)
        g2u_pkg::CMD_LOAD: begin
          if (it.map_index < g2u_pkg::MAP_DEPTH) begin
            map_mem[it.map_index] = {it.map_unicode, it.map_utf8};
            written[it.map_index] = 1'b1;
            loads++;
          end
        end
        g2u_pkg::CMD_START: begin
          held_entry   = '0;
          lead_pending = 1'b0;
          lead_byte    = '0;
        end
        g2u_pkg::CMD_CONVERT: begin
          if (!lead_pending) begin
            if (b < g2u_pkg::HIGH_MIN) begin
              if (out_format == FMT_UCS2) push_code_unit({8'h00, b});
              else push_byte(b, 1'b1);
            end else begin
              lead_pending = 1'b1;
              lead_byte    = b;
            end
          end else begin
            // Any byte completes the pair; only a well-formed one refreshes the held entry.
            lead_pending = 1'b0;
            if (is_mapped_pair(lead_byte, b)) held_entry = map_mem[map_addr(lead_byte, b)];
            if (out_format == FMT_UCS2) begin
              push_code_unit(held_entry[g2u_pkg::ENTRY_W-1 -: g2u_pkg::UNI_W]);
            end else begin
              push_byte(held_entry[23:16], 1'b0);
              push_byte(held_entry[15:8], 1'b0);
              push_byte(held_entry[7:0], 1'b1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(g2u_pkg::out_item_t got);
      g2u_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("out_byte: expected none, got %02h (last %0b)", got.out_byte, got.last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  g2u_pkg::in_item_t             in_item   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  g2u_pkg::out_item_t            out_item;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [g2u_pkg::CFG_AW-1:0]    paddr     = '0;
  logic [g2u_pkg::CFG_DW-1:0]    pwdata    = '0;
  logic [g2u_pkg::CFG_DW-1:0]    prdata;
  logic                          pready;

  transcode_scoreboard  sb = new;
  int                   cycle_count = 0;
  int                   burst_left  = 0;
  int                   counted     = 0;
  stall_mode_t          stall_mode  = RX_STEADY;

  gb2312_to_unicode_transcoder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Receiver stall pattern is redrawn at random from steady, light, heavy and block modes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_STEADY: out_stall <= 1'b0;
      RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:  out_stall <= 1'($urandom_range(0, 1));
      default:   out_stall <= (cycle_count % 16) < 11;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_byte(out_item);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [g2u_pkg::UNI_W-1:0] rand_uni();
    return g2u_pkg::UNI_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [g2u_pkg::UTF8_W-1:0] rand_utf8();
    return g2u_pkg::UTF8_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic g2u_pkg::in_item_t rand_item(logic [1:0] cmd);
    g2u_pkg::in_item_t it;
    it.cmd         = cmd;
    it.data_byte   = 8'($urandom_range(0, 255));
    it.map_index   = g2u_pkg::IDX_W'($urandom_range(0, 16383));
    it.map_unicode = rand_uni();
    it.map_utf8    = rand_utf8();
    return it;
  endfunction

  // Sender works in bursts; a gap only starts once the previous burst has run out.
  task automatic send_item(input g2u_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 16));
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.accept_source(it);
    burst_left--;
    if (it.cmd != CMD_UNUSED
        && !(it.cmd == g2u_pkg::CMD_LOAD && it.map_index >= g2u_pkg::MAP_DEPTH)) counted++;
  endtask

  task automatic stop_sending();
    in_valid   <= 1'b0;
    burst_left = 0;
  endtask

  task automatic send_load(input logic [g2u_pkg::IDX_W-1:0] idx,
                           input logic [g2u_pkg::UNI_W-1:0] uni,
                           input logic [g2u_pkg::UTF8_W-1:0] utf8);
    g2u_pkg::in_item_t it;
    it             = rand_item(g2u_pkg::CMD_LOAD);
    it.map_index   = idx;
    it.map_unicode = uni;
    it.map_utf8    = utf8;
    send_item(it);
  endtask

  // A byte that would look up a never-loaded entry gets that entry loaded first.
  task automatic send_convert(input logic [7:0] b);
    g2u_pkg::in_item_t it;
    int unsigned       idx;
    if (sb.lead_pending && sb.is_mapped_pair(sb.lead_byte, b)) begin
      idx = sb.map_addr(sb.lead_byte, b);
      if (!sb.written[idx])
        send_load(g2u_pkg::IDX_W'(idx), rand_uni(), rand_utf8());
    end
    it           = rand_item(g2u_pkg::CMD_CONVERT);
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic write_reg(input logic [g2u_pkg::REG_IDX_W-1:0] idx,
                           input logic [g2u_pkg::CFG_DW-1:0] val);
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    // The address is still on the bus, so the written value reads back on prdata.
    @(posedge clk);
    if (prdata !== g2u_pkg::CFG_DW'(val[0])) begin
      $error("prdata: expected %0h, got %0h", g2u_pkg::CFG_DW'(val[0]), prdata);
      sb.errors++;
    end
  endtask

  task automatic drain_results();
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          target;
    int          pick;
    logic [7:0]  lead;
    logic [7:0]  trail;
    int unsigned idx;
    fmt_t        fmt;
    order_t      ord;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme entries and indexes, ASCII bounds, broken pairs with a bad lead, a bad trail or both.
    send_load(g2u_pkg::IDX_W'(1409), 16'hFFFF, 24'hFFFFFF);
    send_load(g2u_pkg::IDX_W'(8177), 16'h4E2D, 24'hE4B8AD);
    send_load(g2u_pkg::IDX_W'(0), 16'h0000, 24'h000000);
    send_load(g2u_pkg::IDX_W'(g2u_pkg::MAP_DEPTH - 1), 16'h8000, 24'h800000);
    send_load(g2u_pkg::IDX_W'(16383), 16'h1234, 24'h123456);
    send_convert(8'h00);
    send_convert(8'h7F);
    send_convert(g2u_pkg::LEAD_MIN);
    send_convert(g2u_pkg::TRAIL_MIN);
    send_convert(g2u_pkg::LEAD_MAX);
    send_convert(g2u_pkg::TRAIL_MAX);
    send_convert(8'h80);
    send_convert(8'h41);
    send_convert(8'hFF);
    send_convert(8'hFF);
    send_convert(g2u_pkg::LEAD_MIN);
    send_convert(8'hFF);
    send_item(rand_item(CMD_UNUSED));
    send_item(rand_item(g2u_pkg::CMD_START));
    send_convert(g2u_pkg::ROW_BASE);
    send_convert(g2u_pkg::ROW_BASE);
    send_convert(8'hB0);
    send_item(rand_item(g2u_pkg::CMD_START));
    send_convert(8'h41);
    stop_sending();

    for (int p = 0; p < 4; p++) begin
      drain_results();
      fmt = (p < 2) ? FMT_UCS2 : FMT_UTF8;
      ord = (p == 1 || p == 2) ? LO_FIRST : HI_FIRST;
      write_reg(g2u_pkg::REG_OUT_FORMAT, g2u_pkg::CFG_DW'(fmt));
      write_reg(g2u_pkg::REG_BYTE_ORDER, g2u_pkg::CFG_DW'(ord));
      target = counted + RANDOM_PER_PHASE;
      while (counted < target) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 50) begin
          // Well-formed pair whose entry is loaded beforehand when needed.
          lead  = 8'($urandom_range(g2u_pkg::LEAD_MIN, g2u_pkg::LEAD_MAX));
          trail = 8'($urandom_range(g2u_pkg::TRAIL_MIN, g2u_pkg::TRAIL_MAX));
          idx   = sb.map_addr(lead, trail);
          if (!sb.written[idx])
            send_load(g2u_pkg::IDX_W'(idx), rand_uni(), rand_utf8());
          send_convert(lead);
          send_convert(trail);
        end else if (pick < 70) begin
          send_convert(8'($urandom_range(0, 127)));
        end else if (pick < 80) begin
          send_convert(8'($urandom_range(128, 255)));
          send_convert(8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
          send_item(rand_item(g2u_pkg::CMD_START));
        end else if (pick < 92) begin
          send_load(g2u_pkg::IDX_W'($urandom_range(0, g2u_pkg::MAP_DEPTH - 1)),
                    rand_uni(), rand_utf8());
        end else if (pick < 96) begin
          send_load(g2u_pkg::IDX_W'($urandom_range(g2u_pkg::MAP_DEPTH, 16383)),
                    rand_uni(), rand_utf8());
        end else begin
          send_item(rand_item(CMD_UNUSED));
        end
      end
      stop_sending();
    end

    drain_results();
    $display("Sent %0d source items including %0d map loads; checked %0d result bytes.",
             counted, sb.loads, sb.checked);
    $display("Covered UTF-8 and UCS-2 output in both byte orders under random stalls.");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/g2u_pkg.sv
rtl/core/g2u_front.sv
rtl/core/g2u_queue.sv
rtl/core/g2u_back.sv
rtl/core/gb2312_to_unicode_transcoder_unit.sv
dv/gb2312_to_unicode_transcoder_unit_tb.sv
